[sv/afrg_pkg.sv]
// shared types, constants and helpers of the additive feedback random generator
`timescale 1ns / 1ps
`default_nettype none

package afrg_pkg;

    localparam int WORD_W   = 32;
    localparam int VALUE_W  = 31;
    localparam int IDX_W    = 5;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 2;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [VALUE_W-1:0]   t_value;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SEED  = 2'd0;
    localparam t_cfg_idx CFG_LIMIT = 2'd1;

    localparam int RING_LEN      = 31;
    localparam int RING_SEP      = 3;
    localparam int DISCARDS      = 310;
    localparam int DISC_W        = 9;
    localparam int DRAW_BUDGET_W = 20;

    localparam int LCG_A = 16807;
    localparam int LCG_Q = 127773;
    localparam int LCG_R = 2836;
    localparam longint LCG_M = 64'd2147483647;

    localparam int LCG_A_W = 15;
    localparam int PROD_W  = WORD_W + LCG_A_W;

    localparam t_word SEED_RESET = 32'd1;

    function automatic t_idx next_idx(input t_idx i);
        next_idx = (i == t_idx'(RING_LEN - 1)) ? '0 : t_idx'(i + 1'b1);
    endfunction

endpackage

`default_nettype wire

[sv/additive_feedback_random_generator.sv]
// top level of the additive feedback random generator: sequencer, seeding unit and output register
//
//  channel   direction  handshake                  payload
//  request   in         i_valid / o_stall          i_run_count
//  result    out        o_valid / i_stall          o_rand_value, o_rand_low_two, o_run_last
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  each draw reads the front and rear words through the two read ports of the ring ram, then writes back
//  seeding writes word 0, derives words 1 to 30 and makes 310 discard draws before the first draw of a request
//  (per word: setup, product, fold, reduce and write)
//  reset is synchronous, active low; the ring itself is not cleared
//  a stalled result holds the sequencer only when the next accepted value is ready
//  a request is taken only when the sequencer is idle
`timescale 1ns / 1ps
`default_nettype none

module additive_feedback_random_generator #(
    parameter int MAX_RUN = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire afrg_pkg::t_count    i_run_count,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output afrg_pkg::t_value         o_rand_value,
    output logic [1:0]               o_rand_low_two,
    output logic                     o_run_last,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire afrg_pkg::t_cfg_idx  i_cfg_index,
    input  wire afrg_pkg::t_word     i_cfg_data
);

    import afrg_pkg::*;

    localparam int WANT_W = $clog2(MAX_RUN + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEED0 = 4'd1;
    localparam logic [3:0] S_DSET  = 4'd2;
    localparam logic [3:0] S_FOLD  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_LCG   = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_WR    = 4'd7;

    logic [3:0]              r_state;
    logic                    r_seeded;
    t_word                   r_seed;
    t_value                  r_limit;
    t_idx                    r_front;
    t_idx                    r_rear;
    t_idx                    r_idx;
    logic                    r_discard;
    logic [DISC_W-1:0]       r_disc;
    logic [WANT_W-1:0]       r_want;
    logic [WANT_W-1:0]       r_got;
    logic [DRAW_BUDGET_W-1:0] r_draws;

    t_word                   r_word;
    logic                    r_neg;
    t_word                   r_mag;
    logic [PROD_W-1:0]       r_prod;
    t_word                   r_red;

    logic                    r_out_valid;
    t_value                  r_out_value;
    logic                    r_out_last;

    logic                    in_acc;
    logic                    cfg_wr;
    logic                    seed_wr;
    logic [WANT_W-1:0]       want_in;
    t_word                   word0;
    t_word                   fold;
    t_word                   lcg_next;
    t_word                   rd_a;
    t_word                   rd_b;
    t_word                   sum;
    t_value                  val;
    logic                    hit;
    logic                    last_hit;
    logic                    budget_end;
    logic                    hold;
    logic                    wr_en;
    t_idx                    wr_addr;
    t_word                   wr_data;
    logic                    rd_en;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign seed_wr     = cfg_wr && (i_cfg_index == CFG_SEED);

    assign want_in = (i_run_count > t_count'(MAX_RUN)) ? WANT_W'(MAX_RUN)
                                                      : WANT_W'(i_run_count);
    assign word0   = (r_seed == '0) ? SEED_RESET : r_seed;

    // 16807 * word mod (2^31 - 1), sign restored after the fold
    assign fold     = (r_red >= t_word'(LCG_M)) ? (r_red - t_word'(LCG_M)) : r_red;
    assign lcg_next = (r_neg && (fold != '0)) ? (t_word'(LCG_M) - fold) : fold;

    assign sum        = rd_a + rd_b;
    assign val        = sum[WORD_W-1:1];
    assign hit        = (val < r_limit);
    assign last_hit   = (WANT_W'(r_got + 1'b1) == r_want);
    assign budget_end = &r_draws;
    assign hold       = !r_discard && hit && r_out_valid && i_stall;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_front;
        wr_data = sum;
        case (r_state)
            S_SEED0: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = word0;
            end
            S_LCG: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = lcg_next;
            end
            S_WR: begin
                wr_en   = !hold;
            end
            default: begin
                wr_en   = 1'b0;
            end
        endcase
    end

    assign rd_en = (r_state == S_RD);

    afrg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_LEN)
    ) u_ring (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (r_front),
        .i_rd_addr_b (r_rear),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_seed      <= SEED_RESET;
            r_limit     <= '1;
            r_front     <= '0;
            r_rear      <= '0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_SEED: begin
                        r_seed   <= i_cfg_data;
                        r_seeded <= 1'b0;
                    end
                    CFG_LIMIT: begin
                        r_limit  <= i_cfg_data[VALUE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_want  <= want_in;
                        r_got   <= '0;
                        r_draws <= '0;
                        if (!r_seeded || seed_wr) begin
                            r_state <= S_SEED0;
                        end else if (want_in != '0) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_SEED0: begin
                    r_word  <= word0;
                    r_idx   <= t_idx'(1);
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    r_neg   <= r_word[WORD_W-1];
                    r_mag   <= r_word[WORD_W-1] ? (~r_word + 1'b1) : r_word;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_mag) * PROD_W'(LCG_A);
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_red   <= {1'b0, r_prod[VALUE_W-1:0]}
                               + t_word'(r_prod[PROD_W-1:VALUE_W]);
                    r_state <= S_LCG;
                end
                S_LCG: begin
                    r_word <= lcg_next;
                    if (r_idx == t_idx'(RING_LEN - 1)) begin
                        r_front   <= t_idx'(RING_SEP);
                        r_rear    <= '0;
                        r_disc    <= '0;
                        r_discard <= 1'b1;
                        r_state   <= S_RD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DSET;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_discard) begin
                        r_front <= next_idx(r_front);
                        r_rear  <= next_idx(r_rear);
                        r_disc  <= r_disc + 1'b1;
                        if (r_disc == DISC_W'(DISCARDS - 1)) begin
                            r_discard <= 1'b0;
                            r_seeded  <= 1'b1;
                            r_state   <= (r_want == '0) ? S_IDLE : S_RD;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else if (!hold) begin
                        r_front <= next_idx(r_front);
                        r_rear  <= next_idx(r_rear);
                        r_draws <= r_draws + 1'b1;
                        if (hit) begin
                            r_out_value <= val;
                            r_out_last  <= last_hit;
                            r_out_valid <= 1'b1;
                            r_got       <= r_got + 1'b1;
                        end
                        if ((hit && last_hit) || budget_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rand_value   = r_out_value;
    assign o_rand_low_two = r_out_value[1:0];
    assign o_run_last     = r_out_last;

    a_ring_write_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_SEED0 || r_state == S_LCG || r_state == S_WR))
        else $error("ring written outside a write state");

    a_lag_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_WR) |->
        (r_front == ((r_rear >= t_idx'(RING_LEN - RING_SEP))
                     ? t_idx'(r_rear - t_idx'(RING_LEN - RING_SEP))
                     : t_idx'(r_rear + t_idx'(RING_SEP)))))
        else $error("front and rear indices lost their separation");

    a_run_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && !r_discard) |-> (r_got < r_want))
        else $error("run drew past its requested count");

    a_lcg_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LCG) |-> (lcg_next < t_word'(LCG_M)))
        else $error("seed word out of range");

    a_hold_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && hold) |=> (r_state == S_WR && r_out_valid))
        else $error("held draw left the write state");

endmodule

`default_nettype wire

[sv/afrg_ram.sv]
// generic ram with one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module afrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

[test/tb_top.sv]
// testbench for the additive feedback random generator: request/result/config stimulus and scoreboard
`timescale 1ns / 1ps

module tb_top;

    import afrg_pkg::*;

    localparam int MAX_RUN     = 64;
    localparam int SEED_CYCLES = 1400;
    localparam int DRAW_BUDGET = 1 << DRAW_BUDGET_W;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 45;

    localparam t_cfg_idx CFG_SPARE_2 = 2'd2;
    localparam t_cfg_idx CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        t_value     value;
        logic [1:0] low_two;
        logic       run_last;
    } rand_result_t;

    class lfg_scoreboard;
        t_word          ring_words[RING_LEN];
        int             front_pos;
        int             rear_pos;
        bit             ring_ready;
        t_word          seed_reg;
        t_value         limit_reg;
        rand_result_t   pending_values[$];
        int             mismatches;
        int             values_checked;
        int             requests_seen;
        int             reseeds;

        function new();
            ring_ready     = 1'b0;
            front_pos      = 0;
            rear_pos       = 0;
            seed_reg       = SEED_RESET;
            limit_reg      = '1;
            mismatches     = 0;
            values_checked = 0;
            requests_seen  = 0;
            reseeds        = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_word data);
            case (idx)
                CFG_SEED: begin
                    seed_reg   = data;
                    ring_ready = 1'b0;
                end
                CFG_LIMIT: begin
                    limit_reg = data[VALUE_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function t_value step_ring();
            t_word sum;
            sum = ring_words[front_pos] + ring_words[rear_pos];
            ring_words[front_pos] = sum;
            front_pos = (front_pos + 1) % RING_LEN;
            rear_pos  = (rear_pos + 1) % RING_LEN;
            return sum[WORD_W-1:1];
        endfunction

        function void reseed_ring();
            longint word;
            longint hi;
            longint lo;
            word = longint'($signed(seed_reg));
            if (word == 0)
                word = 1;
            ring_words[0] = t_word'(word);
            for (int i = 1; i < RING_LEN; i++) begin
                hi = word / LCG_Q;
                lo = word % LCG_Q;
                word = LCG_A * lo - LCG_R * hi;
                if (word < 0)
                    word += LCG_M;
                ring_words[i] = t_word'(word);
            end
            front_pos = RING_SEP;
            rear_pos  = 0;
            repeat (DISCARDS) void'(step_ring());
            ring_ready = 1'b1;
            reseeds++;
        endfunction

        function void note_request(t_count count);
            int           want;
            int           got;
            int           draws;
            t_value       v;
            rand_result_t r;
            requests_seen++;
            if (!ring_ready)
                reseed_ring();
            want  = (count > MAX_RUN) ? MAX_RUN : int'(count);
            got   = 0;
            draws = 0;
            while (got < want && draws < DRAW_BUDGET) begin
                v = step_ring();
                draws++;
                if (v < limit_reg) begin
                    r.value    = v;
                    r.low_two  = v[1:0];
                    r.run_last = 1'b0;
                    pending_values.push_back(r);
                    got++;
                end
            end
            if (got > 0 && got == want)
                pending_values[pending_values.size()-1].run_last = 1'b1;
        endfunction

        function void flag(string what, rand_result_t want, rand_result_t seen);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d, %s: expected %h/%0d/%0b, got %h/%0d/%0b",
                         mismatches, what, want.value, want.low_two, want.run_last,
                         seen.value, seen.low_two, seen.run_last);
        endfunction

        function void check_value(t_value value, logic [1:0] low_two, logic run_last);
            rand_result_t seen;
            rand_result_t want;
            seen.value    = value;
            seen.low_two  = low_two;
            seen.run_last = run_last;
            values_checked++;
            if (pending_values.size() == 0) begin
                flag("no value expected", '0, seen);
            end else begin
                want = pending_values.pop_front();
                if (seen !== want)
                    flag("wrong field", want, seen);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_count     i_run_count;
    logic       o_valid;
    logic       i_stall;
    t_value     o_rand_value;
    logic [1:0] o_rand_low_two;
    logic       o_run_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index;
    t_word      i_cfg_data;

    lfg_scoreboard lfg_sb = new();

    bit tx_calm;
    bit rx_calm;
    int stall_left;
    int rx_gap;

    additive_feedback_random_generator #(
        .MAX_RUN (MAX_RUN)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_run_count    (i_run_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_rand_value   (o_rand_value),
        .o_rand_low_two (o_rand_low_two),
        .o_run_last     (o_run_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_count pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 7)
            return '0;
        if (r < 50)
            return t_count'($urandom_range(1, 8));
        if (r < 70)
            return t_count'($urandom_range(9, 32));
        if (r < 84)
            return t_count'($urandom_range(33, 63));
        if (r < 90)
            return t_count'(MAX_RUN);
        if (r < 97)
            return t_count'($urandom_range(MAX_RUN + 1, 127));
        return t_count'(1);
    endfunction

    function automatic t_word pick_seed();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            4: return 32'hffff_ffff;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_word pick_limit();
        t_value lim;
        int     r;
        r = $urandom_range(0, 9);
        if (r < 4)
            lim = '1;
        else if (r < 7)
            lim = t_value'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
        else
            lim = t_value'($urandom_range(32'h0400_0000, 32'h1000_0000));
        return {1'($urandom_range(0, 1)), lim};
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            rx_gap = rx_calm ? 0 : pick_gap();
            if (rx_gap > 0) begin
                i_stall    <= 1'b1;
                stall_left <= rx_gap - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                lfg_sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall)
                lfg_sb.note_request(i_run_count);
            if (o_valid && !i_stall)
                lfg_sb.check_value(o_rand_value, o_rand_low_two, o_run_last);
        end
    end

    task automatic send_request(input t_count count);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_run_count <= count;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (lfg_sb.pending_values.size() != 0);
    endtask

    task automatic drain_and_settle();
        wait_results();
        repeat (SEED_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input t_word data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_run_count <= '0;
        i_stall     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SEED;
        i_cfg_data  <= '0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        stall_left  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset seed, zero run first, then single, full-length and clamped runs and another zero run
        send_request(t_count'(0));
        send_request(t_count'(1));
        send_request(t_count'(MAX_RUN));
        send_request(t_count'(127));
        send_request(t_count'(MAX_RUN + 1));
        send_request(t_count'(0));
        drain_and_settle();

        cfg_write(CFG_SEED, 32'h0000_0000, 1'b1);
        send_request(t_count'(3));
        drain_and_settle();

        cfg_write(CFG_SEED, 32'h8000_0000, 1'b1);
        send_request(t_count'(0));
        send_request(t_count'(5));
        drain_and_settle();

        cfg_write(CFG_SEED, 32'h7fff_ffff, 1'b0);
        cfg_write(CFG_LIMIT, 32'hffff_ffff, 1'b1);
        send_request(t_count'(MAX_RUN));
        drain_and_settle();

        cfg_write(CFG_SEED, 32'hffff_ffff, 1'b1);
        send_request(t_count'(2));
        drain_and_settle();

        // spare indexes must be ignored
        cfg_write(CFG_SPARE_2, t_word'($urandom), 1'b0);
        cfg_write(CFG_SPARE_3, t_word'($urandom), 1'b1);
        send_request(t_count'(4));
        drain_and_settle();

        cfg_write(CFG_LIMIT, 32'h4000_0000, 1'b1);
        send_request(t_count'(40));
        send_request(t_count'(1));
        drain_and_settle();

        // starved request, then a zero run that is only taken once the budget runs out
        cfg_write(CFG_LIMIT, 32'h0000_0000, 1'b1);
        send_request(t_count'(2));
        send_request(t_count'(0));
        drain_and_settle();

        cfg_write(CFG_LIMIT, 32'h7fff_ffff, 1'b0);
        cfg_write(CFG_SEED, 32'h5555_5555, 1'b1);
        send_request(t_count'(8));

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_and_settle();
            tx_calm = (phase == 2);
            rx_calm = (phase == 3 || phase == 6);
            if ($urandom_range(0, 2) != 0) begin
                cfg_write(CFG_SEED, pick_seed(), 1'b0);
                cfg_write(CFG_LIMIT, pick_limit(), 1'b1);
            end else begin
                cfg_write(CFG_LIMIT, pick_limit(), 1'b1);
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 24) == 0)
                    wait_results();
                send_request(pick_count());
            end
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        drain_and_settle();

        $display("covered %0d requests, %0d values checked, %0d ring reseeds",
                 lfg_sb.requests_seen, lfg_sb.values_checked, lfg_sb.reseeds);
        $display("seeds at zero and both sign extremes, limits from zero to full scale");
        if (lfg_sb.pending_values.size() != 0)
            $display("%0d expected values never arrived", lfg_sb.pending_values.size());
        if (lfg_sb.mismatches == 0 && lfg_sb.pending_values.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
sv/afrg_pkg.sv
sv/afrg_ram.sv
sv/additive_feedback_random_generator.sv
test/tb_top.sv
